/* sv/shape_raster_canvas_core_defines.svh */
// ---------------------------------------------------------------------------
// Shape raster canvas assertion macros
// Shared concurrent assertion shorthands for the canvas core.
// ---------------------------------------------------------------------------
`ifndef SHAPE_RASTER_CANVAS_CORE_DEFINES_SVH
`define SHAPE_RASTER_CANVAS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, muted in reset.
`define SRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, muted in reset.
`define SRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/src_pkg.sv */
// ---------------------------------------------------------------------------
// Shape raster canvas package
// Canvas geometry, command codes and the word types of both channels.
// ---------------------------------------------------------------------------
package src_pkg;

  localparam int CANVAS_ROWS = 16;
  localparam int CANVAS_COLS = 32;
  localparam int ROW_W       = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
  localparam int CNT_W       = $clog2(CANVAS_ROWS + 1);
  localparam int OUT_W       = 32;
  localparam int RSQ_W       = 12;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_RECT   = 3'd1;
  localparam logic [2:0] CMD_LINE   = 3'd2;
  localparam logic [2:0] CMD_TRI    = 3'd3;
  localparam logic [2:0] CMD_CIRCLE = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] row;
    logic [5:0] col;
    logic [6:0] width;
    logic [6:0] height;
    logic [5:0] end_col;
    logic [5:0] radius;
  } in_word_t;

  typedef struct packed {
    logic [31:0] row_bits;
    logic        status;
  } out_word_t;

endpackage

/* sv/shape_raster_canvas_core.sv */
// ---------------------------------------------------------------------------
// Shape raster canvas core
// One-bit-per-cell canvas held in a row-wide RAM, drawn by row sweeps.
// ---------------------------------------------------------------------------
//
//   channel  ports                      handshake
//   -------  -------------------------  ----------------------------------
//   input    start, busy, in_data       word taken when start && !busy
//   result   out_strobe, out_data       word valid for one cycle, no stall
//
// A drawing command (rectangle, line, triangle, circle) sweeps every canvas
// row through the RAM: one row is read per cycle while the previous row is
// written back, and the block stays busy until the last row is written.
// Clear and unused codes never raise busy; read row waits for one RAM read,
// unless the requested row lies off the canvas and no RAM read is needed.
// Reset is synchronous and active low; it blanks the canvas at once through
// per-row valid bits, as does the clear command.
// The result word appears the cycle after the work ends, with busy already
// low, and the receiver cannot hold it off.
// ---------------------------------------------------------------------------
`include "shape_raster_canvas_core_defines.svh"

module shape_raster_canvas_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  src_pkg::in_word_t  in_data,
  output logic               out_strobe,
  output src_pkg::out_word_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_RDWAIT = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  src_pkg::in_word_t                cmd_r, cmd_nxt;
  logic [src_pkg::RSQ_W-1:0]        rsq_r, rsq_nxt;
  logic [src_pkg::CNT_W-1:0]        rd_cnt_r, rd_cnt_nxt;
  logic                             pend_r, pend_nxt;
  logic [src_pkg::ROW_W-1:0]        prow_r, prow_nxt;
  logic [src_pkg::CANVAS_ROWS-1:0]  valid_r, valid_nxt;
  logic                             out_strobe_r, out_strobe_nxt;
  src_pkg::out_word_t               out_data_r, out_data_nxt;

  logic                             accept;
  logic                             row_in_range;
  logic                             we, re;
  logic [src_pkg::ROW_W-1:0]        raddr;
  logic [src_pkg::CANVAS_COLS-1:0]  rdata, wdata, mask, old_word;

  assign busy         = (state_r != ST_IDLE);
  assign accept       = start && !busy;
  assign row_in_range = ({1'b0, in_data.row} < 7'(src_pkg::CANVAS_ROWS));
  assign out_strobe   = out_strobe_r;
  assign out_data     = out_data_r;

  // The sweep reads row rd_cnt while row prow (read in the previous cycle) is
  // merged and written back, so read and write never meet on one row.
  assign old_word = valid_r[prow_r] ? rdata : '0;
  assign wdata    = old_word | mask;

  src_row_mask u_mask (
    .cmd     (cmd_r),
    .row_idx (prow_r),
    .rsq     (rsq_r),
    .mask    (mask)
  );

  src_ram #(
    .W (src_pkg::CANVAS_COLS),
    .D (src_pkg::CANVAS_ROWS)
  ) u_canvas (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (prow_r),
    .wr_data (wdata),
    .rd_en   (re),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    rsq_nxt        = rsq_r;
    rd_cnt_nxt     = rd_cnt_r;
    pend_nxt       = 1'b0;
    prow_nxt       = prow_r;
    valid_nxt      = valid_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    we             = 1'b0;
    re             = 1'b0;
    raddr          = rd_cnt_r[src_pkg::ROW_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_data;
          rsq_nxt    = src_pkg::RSQ_W'(in_data.radius * in_data.radius);
          rd_cnt_nxt = '0;
          out_data_nxt = '0;
          case (in_data.command)
            src_pkg::CMD_CLEAR: begin
              valid_nxt      = '0;
              out_strobe_nxt = 1'b1;
            end
            src_pkg::CMD_RECT, src_pkg::CMD_LINE,
            src_pkg::CMD_TRI, src_pkg::CMD_CIRCLE: begin
              state_nxt = ST_SWEEP;
            end
            src_pkg::CMD_READ: begin
              out_data_nxt.status = 1'b1;
              if (row_in_range) begin
                re        = 1'b1;
                raddr     = in_data.row[src_pkg::ROW_W-1:0];
                state_nxt = ST_RDWAIT;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (pend_r) begin
          we                = 1'b1;
          valid_nxt[prow_r] = 1'b1;
        end
        if (rd_cnt_r != src_pkg::CNT_W'(src_pkg::CANVAS_ROWS)) begin
          re         = 1'b1;
          pend_nxt   = 1'b1;
          prow_nxt   = rd_cnt_r[src_pkg::ROW_W-1:0];
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end else if (pend_r) begin
          out_data_nxt   = '0;
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        out_data_nxt.row_bits = valid_r[cmd_r.row[src_pkg::ROW_W-1:0]] ?
                                src_pkg::OUT_W'(rdata) : '0;
        out_data_nxt.status   = 1'b1;
        out_strobe_nxt        = 1'b1;
        state_nxt             = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_cnt_r     <= '0;
      pend_r       <= 1'b0;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      pend_r       <= pend_nxt;
      valid_r      <= valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rsq_r      <= rsq_nxt;
    prow_r     <= prow_nxt;
    out_data_r <= out_data_nxt;
  end

  // A result word is only ever shown once the block has gone idle.
  `SRC_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result word while busy")
  // A clear command answers in the very next cycle.
  `SRC_ASSERT_NXT(a_clear_fast, accept && (in_data.command == src_pkg::CMD_CLEAR),
                  out_strobe && !busy, "clear did not finish in one cycle")
  // The sweep never reads the row it is writing back.
  `SRC_ASSERT_NOW(a_no_rw_clash, we && re, raddr != prow_r, "read and write on one row")
  // A rectangle or circle command starts a sweep that keeps the block busy.
  `SRC_ASSERT_NXT(a_draw_busy, accept && ((in_data.command == src_pkg::CMD_RECT) ||
                  (in_data.command == src_pkg::CMD_CIRCLE)), busy && !out_strobe,
                  "drawing command did not start its sweep")

endmodule

/* sv/src_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module src_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] wr_addr,
  input  logic [W-1:0]                        wr_data,
  input  logic                                rd_en,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] rd_addr,
  output logic [W-1:0]                        rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/src_row_mask.sv */
// ---------------------------------------------------------------------------
// Shape raster canvas row mask
// Works out, for one canvas row, which cells the current shape marks.
// ---------------------------------------------------------------------------
module src_row_mask (
  input  src_pkg::in_word_t                cmd,
  input  logic [src_pkg::ROW_W-1:0]        row_idx,
  input  logic [src_pkg::RSQ_W-1:0]        rsq,
  output logic [src_pkg::CANVAS_COLS-1:0]  mask
);

  logic signed [9:0]  rs, cs, ws, hs, es, is, bot, di, ady;
  logic        [13:0] dy2;
  logic        [14:0] lo, hi;
  logic               on_hrow, in_vr, in_tri;

  assign rs  = $signed({4'b0, cmd.row});
  assign cs  = $signed({4'b0, cmd.col});
  assign ws  = $signed({3'b0, cmd.width});
  assign hs  = $signed({3'b0, cmd.height});
  assign es  = $signed({4'b0, cmd.end_col});
  assign is  = $signed(10'(row_idx));
  assign bot = rs + hs - 10'sd1;
  assign di  = is - rs;
  assign ady = (di < 0) ? -di : di;
  assign dy2 = 14'(ady[6:0] * ady[6:0]);
  assign lo  = 15'(rsq) - 15'(cmd.radius);
  assign hi  = 15'(rsq) + 15'(cmd.radius);

  assign on_hrow = (is == rs) || (is == bot);
  assign in_vr   = (is >= rs) && (is < rs + hs);
  assign in_tri  = (di >= 0) && (di < hs);

  for (genvar j = 0; j < src_pkg::CANVAS_COLS; j++) begin : g_col
    logic signed [9:0]  js, dx, adx;
    logic        [13:0] dx2;
    logic        [14:0] d;
    logic               m_rect, m_line, m_tri, m_circ;

    assign js  = 10'(j);
    assign dx  = js - cs;
    assign adx = (dx < 0) ? -dx : dx;
    assign dx2 = 14'(adx[6:0] * adx[6:0]);
    assign d   = 15'(dx2) + 15'(dy2);

    assign m_rect = (on_hrow && (js >= cs) && (js < cs + ws)) ||
                    (in_vr && ((js == cs) || (js == cs + ws - 10'sd1)));
    assign m_line = (is == rs) && (js >= cs) && (js <= es);
    assign m_tri  = (in_tri && ((js == cs - di) || (js == cs + di))) ||
                    ((is == bot) && (js >= cs - hs + 10'sd1) && (js <= cs + hs - 10'sd1));
    assign m_circ = (d >= lo) && (d <= hi);

    always_comb begin
      case (cmd.command)
        src_pkg::CMD_RECT:   mask[j] = m_rect;
        src_pkg::CMD_LINE:   mask[j] = m_line;
        src_pkg::CMD_TRI:    mask[j] = m_tri;
        src_pkg::CMD_CIRCLE: mask[j] = m_circ;
        default:             mask[j] = 1'b0;
      endcase
    end
  end

endmodule

/* bench/shape_raster_canvas_core_tb.sv */
// ---------------------------------------------------------------------------
// Shape raster canvas core testbench
// Drives drawing, clear, read-row and unused command words into the canvas
// core, predicts each result word from a shadow canvas and checks it as it appears.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the shadow canvas and the queue of result words still to come.
class canvas_board;
  logic [63:0]        shadow [src_pkg::CANVAS_ROWS];
  src_pkg::out_word_t pending [$];
  int                 errors;

  function new();
    clear_canvas();
    errors = 0;
  endfunction

  function void clear_canvas();
    for (int i = 0; i < src_pkg::CANVAS_ROWS; i++) shadow[i] = '0;
  endfunction

  // Drops any mark outside the canvas, negative ones included.
  function void plot(int r, int c);
    if (r < 0 || r >= src_pkg::CANVAS_ROWS || c < 0 || c >= src_pkg::CANVAS_COLS) return;
    shadow[r][c] = 1'b1;
  endfunction

  // Applies one accepted command word and queues its expected result.
  function void note_command(src_pkg::in_word_t w);
    src_pkg::out_word_t res;
    int r, c, wd, ht, ec, rad, rsq, d;
    res = '0;
    r = int'(w.row); c = int'(w.col); wd = int'(w.width); ht = int'(w.height);
    ec = int'(w.end_col); rad = int'(w.radius);
    case (w.command)
      src_pkg::CMD_CLEAR: clear_canvas();
      src_pkg::CMD_RECT: begin
        for (int i = c; i < c + wd; i++) begin
          plot(r, i);
          plot(r + ht - 1, i);
        end
        for (int i = r; i < r + ht; i++) begin
          plot(i, c);
          plot(i, c + wd - 1);
        end
      end
      src_pkg::CMD_LINE: for (int i = c; i <= ec; i++) plot(r, i);
      src_pkg::CMD_TRI: begin
        for (int i = 0; i < ht; i++) begin
          plot(r + i, c - i);
          plot(r + i, c + i);
        end
        for (int i = c - ht + 1; i <= c + ht - 1; i++) plot(r + ht - 1, i);
      end
      src_pkg::CMD_CIRCLE: begin
        rsq = rad * rad;
        for (int i = 0; i < src_pkg::CANVAS_ROWS; i++)
          for (int j = 0; j < src_pkg::CANVAS_COLS; j++) begin
            d = (i - r) * (i - r) + (j - c) * (j - c);
            if (d >= rsq - rad && d <= rsq + rad) plot(i, j);
          end
      end
      src_pkg::CMD_READ: begin
        if (r < src_pkg::CANVAS_ROWS) res.row_bits = shadow[r][31:0];
        res.status = 1'b1;
      end
      default: ;
    endcase
    pending.push_back(res);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    errors++;
  endtask

  task check_result(src_pkg::out_word_t got);
    src_pkg::out_word_t want;
    if (pending.size() == 0) begin
      report("unexpected word", got.row_bits, '0);
      return;
    end
    want = pending.pop_front();
    if (got.row_bits !== want.row_bits) report("row_bits", got.row_bits, want.row_bits);
    if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
  endtask
endclass

module shape_raster_canvas_core_tb;
  localparam int STALL_LIMIT = 2000;
  // The two command codes that the core leaves unused.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  src_pkg::in_word_t  in_data;
  logic               out_strobe;
  src_pkg::out_word_t out_data;

  canvas_board board;
  int  idle_cycles;
  int  words_sent;
  int  reads_sent;
  bit  gaps_on;

  shape_raster_canvas_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: the core cannot be stalled, so every strobe is checked at
  // the edge that ends it. The watchdog counts edges with no handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) board.check_result(out_data);
      if (out_strobe || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Holds start high until the core takes the word, then notes it. Start is
  // lowered only when a gap follows, so a back-to-back word keeps it high.
  task automatic send_word(src_pkg::in_word_t w);
    int gap;
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(w);
    words_sent++;
    if (w.command == src_pkg::CMD_READ) reads_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = int'($urandom_range(1, 18));
      start   <= 1'b0;
      in_data <= src_pkg::in_word_t'(41'($urandom));
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic src_pkg::in_word_t make_word(logic [2:0] cmd, int r, int c, int wd,
                                                  int ht, int ec, int rad);
    src_pkg::in_word_t w;
    w.command = cmd; w.row = 6'(r); w.col = 6'(c); w.width = 7'(wd);
    w.height = 7'(ht); w.end_col = 6'(ec); w.radius = 6'(rad);
    return w;
  endfunction

  // Reads every canvas row, so that each drawing is seen in full.
  task automatic read_all();
    for (int i = 0; i < src_pkg::CANVAS_ROWS; i++)
      send_word(make_word(src_pkg::CMD_READ, i, int'($urandom), int'($urandom),
                          int'($urandom), int'($urandom), int'($urandom)));
  endtask

  // Mostly row reads and small shapes on or near the canvas so it stays legible; now and
  // then random fields, width and height at most 64, including unused codes.
  function automatic src_pkg::in_word_t random_word();
    src_pkg::in_word_t w;
    int pick;
    w = src_pkg::in_word_t'(41'({$urandom, $urandom}));
    pick = int'($urandom_range(0, 99));
    if (pick < 40) begin
      w.command = src_pkg::CMD_READ;
      w.row = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, src_pkg::CANVAS_ROWS - 1));
    end else if (pick < 85) begin
      w.command = 3'($urandom_range(int'(src_pkg::CMD_RECT), int'(src_pkg::CMD_CIRCLE)));
      w.row     = 6'($urandom_range(0, 19));
      w.col     = 6'($urandom_range(0, 35));
      w.width   = 7'($urandom_range(0, 20));
      w.height  = 7'($urandom_range(0, 12));
      w.end_col = 6'($urandom_range(0, 35));
      w.radius  = 6'($urandom_range(0, 10));
    end else if (pick < 88) begin
      w.command = src_pkg::CMD_CLEAR;
    end else if (pick < 92) begin
      w.command = ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
    end
    if (w.width > 7'd64) w.width = 7'($urandom_range(0, 64));
    if (w.height > 7'd64) w.height = 7'($urandom_range(0, 64));
    return w;
  endfunction

  initial begin
    board       = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    idle_cycles = 0;
    words_sent  = 0;
    reads_sent  = 0;
    gaps_on     = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty canvas, each shape with its edge cases, then full
    // reads. Zero-size rectangles leave stray cells; a reversed line and a
    // zero-height triangle mark nothing; off-canvas marks are dropped.
    send_word(make_word(src_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(src_pkg::CMD_RECT, 1, 2, 5, 4, 0, 0));
    send_word(make_word(src_pkg::CMD_RECT, 5, 0, 0, 3, 0, 0));
    send_word(make_word(src_pkg::CMD_RECT, 0, 10, 4, 0, 0, 0));
    send_word(make_word(src_pkg::CMD_RECT, 63, 63, 127, 127, 63, 63));
    send_word(make_word(src_pkg::CMD_LINE, 8, 20, 0, 0, 31, 0));
    send_word(make_word(src_pkg::CMD_LINE, 9, 10, 0, 0, 3, 0));
    send_word(make_word(src_pkg::CMD_TRI, 2, 25, 0, 6, 0, 0));
    send_word(make_word(src_pkg::CMD_TRI, 4, 4, 0, 0, 0, 0));
    send_word(make_word(src_pkg::CMD_CIRCLE, 8, 16, 0, 0, 0, 5));
    send_word(make_word(src_pkg::CMD_CIRCLE, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_SPARE_LO, 63, 63, 127, 127, 63, 63));
    send_word(make_word(CMD_SPARE_HI, 0, 0, 0, 0, 0, 0));
    send_word(make_word(src_pkg::CMD_READ, 63, 0, 0, 0, 0, 0));
    read_all();
    send_word(make_word(src_pkg::CMD_CIRCLE, 63, 63, 0, 0, 0, 63));
    read_all();
    send_word(make_word(src_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    read_all();

    // Hold off until every result has come back, then carry on.
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < 1400; n++) begin
      if (n == 1200) gaps_on = 1'b0;
      send_word(random_word());
      if ($urandom_range(0, 199) == 0) read_all();
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d command words, %0d of them row reads, with random gaps",
             words_sent, reads_sent);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/src_pkg.sv
sv/src_ram.sv
sv/src_row_mask.sv
sv/shape_raster_canvas_core.sv
bench/shape_raster_canvas_core_tb.sv
